>>> hw/rtl/cqi_pkg.sv
// cqi_pkg: sizes, codes, types and helper functions for the circular queue
// with interleave unit; no dependencies, compiled first
`timescale 1ns / 1ps

package cqi_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int HALF_DEPTH = DEPTH / 2;
  localparam int ODD_DEPTH  = DEPTH % 2;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SIDE_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int STEP_W     = $clog2(HALF_DEPTH + 1);

  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_REARR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_REARR,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOT_FULL = 2'd3
  } status_t;

  typedef struct packed {
    op_t   op;
    word_t word;
  } op_word_t;

  function automatic word_t to_word(input logic [DATA_W-1:0] d);
    logic [63:0] wide;
    wide = 64'(d);
    return wide[WORD_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] from_word(input word_t w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[DATA_W-1:0];
  endfunction

  // slot of a position relative to the head, one compare and subtract
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] rel);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, rel};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/cqi_if.sv
// cqi_cmd_if and cqi_res_if: valid/ready channels for command and result words
// depends on cqi_pkg for field widths
`timescale 1ns / 1ps

interface cqi_cmd_if import cqi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface cqi_res_if import cqi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output data_out, output status, output count, input ready);
  modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

>>> hw/rtl/cqi_front.sv
// cqi_front: takes command words, decodes them into operations and holds
// them in a two-entry queue for the back end; depends on cqi_pkg, cqi_cmd_if
`timescale 1ns / 1ps

module cqi_front import cqi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  cqi_cmd_if.sink  cmd_ch,
  output logic     op_valid,
  output op_word_t op_out,
  input  logic     op_pop
);

  op_word_t   q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  op_word_t   decoded;

  always_comb begin
    decoded.word = to_word(cmd_ch.data_in);
    case (cmd_t'(cmd_ch.cmd))
      CMD_ENQ:   decoded.op = OP_ENQ;
      CMD_DEQ:   decoded.op = OP_DEQ;
      CMD_REARR: decoded.op = OP_REARR;
      default:   decoded.op = OP_NOP;
    endcase
  end

  assign cmd_ch.ready = (fill != 2'd2);
  assign push         = cmd_ch.valid && cmd_ch.ready;
  assign op_valid     = (fill != 2'd0);
  assign pop          = op_pop && op_valid;
  assign op_out       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/cqi_back.sv
// cqi_back: executes queued operations on the word store and the side store,
// and holds the result word; depends on cqi_pkg, cqi_res_if
`timescale 1ns / 1ps

module cqi_back import cqi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  input  op_word_t op_in,
  output logic     op_pop,
  cqi_res_if.source res_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SPLIT,
    S_LAST_RD,
    S_LAST_WR,
    S_PAIR_RD,
    S_PAIR_E,
    S_PAIR_M
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    head;
  logic [CNT_W-1:0]    held;
  logic [STEP_W-1:0]   step;
  word_t               m_hold;
  logic                out_valid;
  logic [DATA_W-1:0]   out_data;
  status_t             out_status;
  logic [COUNT_W-1:0]  out_count;

  word_t               store [DEPTH];
  word_t               side [HALF_DEPTH];
  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  word_t               st_wdata;
  logic [IDX_W-1:0]    st_raddr;
  word_t               st_rd;
  logic                sd_we;
  logic [SIDE_W-1:0]   sd_waddr;
  word_t               sd_wdata;
  logic [SIDE_W-1:0]   sd_raddr;
  word_t               sd_rd;

  logic                res_free;
  logic                start;
  logic                is_full;
  logic [IDX_W-1:0]    rel_m;
  logic [IDX_W-1:0]    rel_e_dst;

  assign res_free  = !out_valid || res_ch.ready;
  assign start     = (state == S_IDLE) && op_valid && res_free;
  assign op_pop    = start;
  assign is_full   = (held == CNT_W'(DEPTH));
  assign rel_m     = IDX_W'(HALF_DEPTH) + IDX_W'(step);
  assign rel_e_dst = IDX_W'(ODD_DEPTH) + IDX_W'({step, 1'b0});

  assign res_ch.valid    = out_valid;
  assign res_ch.data_out = out_data;
  assign res_ch.status   = out_status;
  assign res_ch.count    = out_count;

  // memory port control
  always_comb begin
    st_we    = 1'b0;
    st_waddr = head;
    st_wdata = st_rd;
    st_raddr = head;
    sd_we    = 1'b0;
    sd_waddr = SIDE_W'(step - 1'b1);
    sd_wdata = st_rd;
    sd_raddr = SIDE_W'(step);
    case (state)
      S_IDLE: begin
        if (start && op_in.op == OP_ENQ && !is_full) begin
          st_we    = 1'b1;
          st_waddr = slot_of(head, IDX_W'(held));
          st_wdata = op_in.word;
        end
      end
      S_SPLIT: begin
        st_raddr = slot_of(head, IDX_W'(step));
        sd_we    = (step != '0);
      end
      S_LAST_RD: begin
        st_raddr = slot_of(head, IDX_W'(DEPTH - 1));
      end
      S_LAST_WR: begin
        st_we    = 1'b1;
        st_waddr = head;
      end
      S_PAIR_RD: begin
        st_raddr = slot_of(head, rel_m);
      end
      S_PAIR_E: begin
        st_we    = 1'b1;
        st_waddr = slot_of(head, rel_e_dst);
        st_wdata = sd_rd;
      end
      S_PAIR_M: begin
        st_we    = 1'b1;
        st_waddr = slot_of(head, rel_e_dst + IDX_W'(1));
        st_wdata = m_hold;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    st_rd <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (sd_we) begin
      side[sd_waddr] <= sd_wdata;
    end
    sd_rd <= side[sd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      held      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (op_in.op)
              OP_ENQ: begin
                out_valid <= 1'b1;
                out_data  <= '0;
                if (!is_full) begin
                  held       <= held + 1'b1;
                  out_status <= ST_OK;
                  out_count  <= COUNT_W'(held + 1'b1);
                end else begin
                  out_status <= ST_FULL;
                  out_count  <= COUNT_W'(held);
                end
              end
              OP_DEQ: begin
                if (held == '0) begin
                  out_valid  <= 1'b1;
                  out_data   <= from_word('1);
                  out_status <= ST_EMPTY;
                  out_count  <= '0;
                end else begin
                  state <= S_DEQ;
                  held  <= held - 1'b1;
                  if (held == CNT_W'(1) || head == IDX_W'(DEPTH - 1)) begin
                    head <= '0;
                  end else begin
                    head <= head + 1'b1;
                  end
                end
              end
              OP_REARR: begin
                if (!is_full) begin
                  out_valid  <= 1'b1;
                  out_data   <= '0;
                  out_status <= ST_NOT_FULL;
                  out_count  <= COUNT_W'(held);
                end else begin
                  step  <= '0;
                  state <= S_SPLIT;
                end
              end
              default: begin
                out_valid  <= 1'b1;
                out_data   <= '0;
                out_status <= ST_OK;
                out_count  <= COUNT_W'(held);
              end
            endcase
          end
        end
        S_DEQ: begin
          out_valid  <= 1'b1;
          out_data   <= from_word(st_rd);
          out_status <= ST_OK;
          out_count  <= COUNT_W'(held);
          state      <= S_IDLE;
        end
        S_SPLIT: begin
          if (step == STEP_W'(HALF_DEPTH)) begin
            step  <= '0;
            state <= (ODD_DEPTH != 0) ? S_LAST_RD : S_PAIR_RD;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_LAST_RD: begin
          state <= S_LAST_WR;
        end
        S_LAST_WR: begin
          state <= S_PAIR_RD;
        end
        S_PAIR_RD: begin
          state <= S_PAIR_E;
        end
        S_PAIR_E: begin
          m_hold <= st_rd;
          state  <= S_PAIR_M;
        end
        S_PAIR_M: begin
          if (step == STEP_W'(HALF_DEPTH - 1)) begin
            out_valid  <= 1'b1;
            out_data   <= '0;
            out_status <= ST_OK;
            out_count  <= COUNT_W'(held);
            state      <= S_IDLE;
          end else begin
            step  <= step + 1'b1;
            state <= S_PAIR_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("held count beyond depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= IDX_W'(DEPTH - 1))
    else $error("head slot out of range");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    held == '0 |-> head == '0)
    else $error("empty queue with nonzero head");

  a_rearr_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT || state == S_LAST_RD || state == S_LAST_WR ||
     state == S_PAIR_RD || state == S_PAIR_E || state == S_PAIR_M)
    |=> $stable(held) && $stable(head))
    else $error("count or head moved during rearrange");

  a_rearr_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT || state == S_LAST_RD || state == S_LAST_WR ||
     state == S_PAIR_RD || state == S_PAIR_E || state == S_PAIR_M)
    |-> !out_valid)
    else $error("result pending while rearrange runs");

endmodule

>>> hw/rtl/circular_queue_with_interleave_unit.sv
// Circular queue of DEPTH signed words with enqueue, dequeue and a rearrange
// that interleaves the older half with the newer half of a full queue. A front
// end decodes each command word into a two-entry queue; the back end executes
// it against a word store with one write port and one read port and returns one result word per command
// through an output register. Enqueue, rejected commands and the unused
// command are settled in the idle state; dequeue adds a registered store read.
// Rearrange copies the older half to a side store, then writes the words back
// in pairs (newest word first for odd DEPTH), one at a time through the one write port of the word store.
// The front end keeps accepting up to two command words while the back end works.
`timescale 1ns / 1ps

module circular_queue_with_interleave_unit import cqi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cqi_cmd_if.sink   cmd_ch,
  cqi_res_if.source res_ch
);

  logic     op_valid;
  op_word_t op_word;
  logic     op_pop;

  cqi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_ch   (cmd_ch),
    .op_valid (op_valid),
    .op_out   (op_word),
    .op_pop   (op_pop)
  );

  cqi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_in    (op_word),
    .op_pop   (op_pop),
    .res_ch   (res_ch)
  );

endmodule

>>> sim/circular_queue_with_interleave_unit_tb.sv
// testbench for circular_queue_with_interleave_unit: directed table then random
// command words, each result checked against the table or a queue model kept in this file
// depends on cqi_pkg, cqi_cmd_if, cqi_res_if and the unit itself
`timescale 1ns / 1ps

module circular_queue_with_interleave_unit_tb;
  import cqi_pkg::*;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 4 * HALF_DEPTH + 12;
  localparam int DIRECTED_ROWS   = 25;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  typedef struct packed {
    cmd_t              op;
    logic [DATA_W-1:0] word;
    logic              typed;
    queue_result_t     want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  cqi_cmd_if cmd_ch ();
  cqi_res_if res_ch ();

  circular_queue_with_interleave_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // queue model state
  word_t model_mem [DEPTH];
  int    model_head = 0;
  int    model_held = 0;

  queue_result_t pending_results [$];

  int   errors       = 0;
  int   n_sent       = 0;
  int   n_rearranged = 0;
  int   n_full_rej   = 0;
  int   n_empty_rej  = 0;
  int   n_peak_full  = 0;
  int   send_idle    = 0;
  int   recv_idle    = 0;
  logic hold_req;
  int   hold_left    = 0;
  bit   hold_done    = 1'b0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_DEQ,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_EMPTY,    5'd0}},
    '{CMD_REARR, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_NOT_FULL, 5'd0}},
    '{CMD_NONE,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,       5'd0}},
    '{CMD_ENQ,   32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,       5'd1}},
    '{CMD_ENQ,   32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,       5'd2}},
    '{CMD_DEQ,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,       5'd1}},
    '{CMD_DEQ,   32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, ST_OK,       5'd0}},
    '{CMD_ENQ,   32'h0000_0000, 1'b0, '0},
    '{CMD_ENQ,   32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_0001, 1'b0, '0},
    '{CMD_ENQ,   32'h8000_0001, 1'b0, '0},
    '{CMD_ENQ,   32'h7FFF_FFFE, 1'b0, '0},
    '{CMD_ENQ,   32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_ENQ,   32'h5555_5555, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_0108, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_0109, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_010A, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_010B, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_010C, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_010D, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_010E, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_010F, 1'b0, '0},
    '{CMD_ENQ,   32'h0000_0110, 1'b0, '0},
    '{CMD_ENQ,   32'h1234_5678, 1'b1, '{32'h0000_0000, ST_FULL,     5'd16}},
    '{CMD_REARR, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,       5'd16}}
  };

  function automatic queue_result_t exec_queue_cmd(input cmd_t op,
                                                   input logic [DATA_W-1:0] word);
    queue_result_t res;
    word_t         line [DEPTH];
    word_t         ones;
    int            pos;
    res  = '0;
    ones = '1;
    pos  = 0;
    case (op)
      CMD_ENQ: begin
        if (model_held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_mem[(model_head + model_held) % DEPTH] = WORD_WIDTH'(word);
          model_held++;
        end
      end
      CMD_DEQ: begin
        if (model_held == 0) begin
          res.data   = DATA_W'(ones);
          res.status = ST_EMPTY;
        end else begin
          res.data   = DATA_W'(model_mem[model_head]);
          model_head = (model_head + 1) % DEPTH;
          model_held--;
          if (model_held == 0) begin
            model_head = 0;
          end
        end
      end
      CMD_REARR: begin
        if (model_held != DEPTH) begin
          res.status = ST_NOT_FULL;
        end else begin
          // odd depth: newest word leads, then older/newer halves alternate
          if (DEPTH % 2 != 0) begin
            line[pos] = model_mem[(model_head + DEPTH - 1) % DEPTH];
            pos++;
          end
          for (int i = 0; i < HALF_DEPTH; i++) begin
            line[pos]     = model_mem[(model_head + i) % DEPTH];
            line[pos + 1] = model_mem[(model_head + HALF_DEPTH + i) % DEPTH];
            pos += 2;
          end
          model_mem  = line;
          model_head = 0;
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(model_held);
    return res;
  endfunction

  // fill mode leans on enqueue, drain mode on dequeue
  function automatic cmd_t pick_op(input int mode);
    int r;
    r = $urandom_range(99);
    if (model_held == DEPTH && r < 40) begin
      return CMD_REARR;
    end
    case (mode)
      0: begin
        if (r < 75) return CMD_ENQ;
        if (r < 88) return CMD_DEQ;
        if (r < 96) return CMD_REARR;
        return CMD_NONE;
      end
      1: begin
        if (r < 25) return CMD_ENQ;
        if (r < 85) return CMD_DEQ;
        if (r < 93) return CMD_REARR;
        return CMD_NONE;
      end
      default: begin
        if (r < 42) return CMD_ENQ;
        if (r < 80) return CMD_DEQ;
        if (r < 92) return CMD_REARR;
        return CMD_NONE;
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input cmd_t op, input logic [DATA_W-1:0] word,
                           input logic typed, input queue_result_t typed_res);
    queue_result_t got;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.cmd     <= op;
    cmd_ch.data_in <= word;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    got = exec_queue_cmd(op, word);
    pending_results.push_back(typed ? typed_res : got);
    n_sent++;
    if (op == CMD_REARR && got.status == ST_OK) n_rearranged++;
    if (got.status == ST_FULL) n_full_rej++;
    if (got.status == ST_EMPTY) n_empty_rej++;
    if (got.count == COUNT_W'(DEPTH)) n_peak_full++;
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      res_ch.ready <= 1'b0;
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: data_out %h status %0d count %0d",
               res_ch.data_out, res_ch.status, res_ch.count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.data_out !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, res_ch.data_out);
          errors++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          errors++;
        end
        if (res_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, res_ch.count);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int   mode;
    int   left;
    cmd_t op;
    mode           = 0;
    left           = 0;
    rst            <= 1'b1;
    hold_req       <= 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.cmd     <= CMD_NONE;
    cmd_ch.data_in <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      case (ph)
        0: begin
          send_idle = 12;
          recv_idle = 81;
        end
        1: begin
          send_idle = 81;
          recv_idle = 12;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          hold_req  <= 1'b1;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (left == 0) begin
          mode = $urandom_range(2);
          left = $urandom_range(8, 40);
        end
        left--;
        op = pick_op(mode);
        send_word(op, pick_word(), 1'b0, '0);
      end
    end

    drain_results();
    $display("%0d command words sent: %0d interleaves of a full queue, %0d results at full",
             n_sent, n_rearranged, n_peak_full);
    $display("%0d enqueues refused as full, %0d dequeues on empty, %0d mismatches",
             n_full_rej, n_empty_rej, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> circular_queue_with_interleave_unit.f
hw/rtl/cqi_pkg.sv
hw/rtl/cqi_if.sv
hw/rtl/cqi_front.sv
hw/rtl/cqi_back.sv
hw/rtl/circular_queue_with_interleave_unit.sv
sim/circular_queue_with_interleave_unit_tb.sv
